[hdl/handheld_io_register_file_core_defines.svh]
// ----------------------------------------------------------------------------
// handheld_io_register_file_core_defines.svh
// Assertion macros shared by the I/O register file RTL.
// ----------------------------------------------------------------------------
`ifndef HANDHELD_IO_REGISTER_FILE_CORE_DEFINES_SVH
`define HANDHELD_IO_REGISTER_FILE_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define HIORF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define HIORF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[hdl/hiorf_pkg.sv]
// ----------------------------------------------------------------------------
// hiorf_pkg
// Types, register offsets and read masks of the I/O register window.
// ----------------------------------------------------------------------------
`default_nettype none

package hiorf_pkg;

  localparam int WINDOW_BYTES = 128;
  localparam int ADDR_W       = $clog2(WINDOW_BYTES);

  typedef logic [ADDR_W-1:0] addr_t;

  // Bus access codes; the other codes are command errors
  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1
  } action_t;

  // Register offsets from the window base
  localparam addr_t ADDR_SQ1_LEN    = 7'h00;
  localparam addr_t ADDR_SQ1_TRIG   = 7'h04;
  localparam addr_t ADDR_SQ2_LEN    = 7'h06;
  localparam addr_t ADDR_SQ2_TRIG   = 7'h09;
  localparam addr_t ADDR_WAVE_ON    = 7'h0A;
  localparam addr_t ADDR_WAVE_LEN   = 7'h0B;
  localparam addr_t ADDR_NOISE_LEN  = 7'h10;
  localparam addr_t ADDR_NOISE_TRIG = 7'h13;
  localparam addr_t ADDR_POWER      = 7'h16;
  localparam addr_t ADDR_SOUND_END  = 7'h20;
  localparam addr_t ADDR_LCD_STAT   = 7'h31;
  localparam addr_t ADDR_DMA        = 7'h36;
  localparam addr_t ADDR_BOOT       = 7'h40;
  localparam addr_t ADDR_LAST       = 7'h7F;

  localparam logic [7:0] POWER_BIT  = 8'h80;
  localparam logic [7:0] STAT_WMASK = 8'h78;

  // Entries wiped when sound power goes off: 0x00-0x1F except the wave enable
  localparam logic [WINDOW_BYTES-1:0] SOUND_CLR_MASK =
    {{(WINDOW_BYTES-32){1'b0}}, 32'hFFFF_FBFF};

  typedef struct packed {
    logic sq1_len;
    logic sq1_trig;
    logic sq2_len;
    logic sq2_trig;
    logic wave_len;
    logic noise_len;
    logic noise_trig;
    logic rom_unmap;
    logic dma_req;
  } pulse_t;

  typedef struct packed {
    logic [7:0] mask;
  } rd_mask_t;

  // Information carried from the accept cycle to the output stage
  typedef struct packed {
    logic       is_read;
    logic       all_ones;
    logic [7:0] mask;
    logic       status;
    pulse_t     pulses;
    logic [7:0] dma_page;
  } meta_t;

  // Bits forced to one on reads
  function automatic logic [7:0] read_or_mask(input addr_t a);
    logic [7:0] m;
    m = 8'h00;
    case (a) inside
      7'h00:                       m = 8'h80;
      7'h01, 7'h06:                m = 8'h3F;
      7'h04, 7'h09, 7'h0E, 7'h13:  m = 8'hBF;
      7'h0A:                       m = 8'h7F;
      7'h0C:                       m = 8'h9F;
      7'h16:                       m = 8'h70;
      default:                     m = 8'h00;
    endcase
    return m;
  endfunction

  // Unused sound addresses read as all ones
  function automatic logic read_all_ones(input addr_t a);
    logic r;
    r = 1'b0;
    case (a) inside
      7'h03, 7'h05, 7'h08, 7'h0B, 7'h0D, 7'h0F, 7'h10: r = 1'b1;
      [7'h17:7'h1F]:                                   r = 1'b1;
      default:                                         r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/handheld_io_register_file_core.sv]
// Pipeline: the store is read into the read stage at the accept edge; the
//   result register loads when that stage advances, which out_ready can hold.
// Throughput: one item per cycle while out_ready does not stall the output;
//   each item takes one store access.
// Reset: control state cleared; per-entry valid bits clear so the whole
//   store reads as zero at once, with no clearing pass.
// ----------------------------------------------------------------------------
// handheld_io_register_file_core
// 128-byte I/O register window: masked reads, sound power rules, event
// pulses and DMA request, one bus access per item.
// ----------------------------------------------------------------------------
`default_nettype none

`include "handheld_io_register_file_core_defines.svh"

module handheld_io_register_file_core
  import hiorf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_action,
  input  wire logic [ADDR_W-1:0] in_reg_address,
  input  wire logic [7:0]  in_write_value,

  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_read_value,
  output logic             out_status,
  output logic             out_sq1_length_reload,
  output logic             out_sq1_trigger,
  output logic             out_sq2_length_reload,
  output logic             out_sq2_trigger,
  output logic             out_wave_length_reload,
  output logic             out_noise_length_reload,
  output logic             out_noise_trigger,
  output logic             out_rom_unmap,
  output logic             out_dma_request,
  output logic [7:0]       out_dma_page
);

  // Storage
  logic [7:0]              mem [WINDOW_BYTES];
  logic [WINDOW_BYTES-1:0] valid_r, valid_nxt;
  logic                    power_r;

  // Read stage
  logic       a_valid_r, a_valid_nxt;
  meta_t      a_meta_r;
  logic [7:0] mem_q_r;
  logic       ent_q_r;

  // Output stage
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_read_r;
  meta_t      out_meta_r;

  logic       in_accept, a_adv;
  logic       is_rd, is_wr, sound_blocked, wr_ok;
  logic       mem_we, power_off;
  logic [7:0] wdata;
  pulse_t     pulses;
  meta_t      meta_in;
  logic [7:0] rd_value;

  // Handshake
  assign a_adv     = a_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !a_valid_r || a_adv;
  assign in_accept = in_valid && in_ready;

  // Decode of the incoming access
  always_comb begin
    is_rd         = (in_action == ACT_READ);
    is_wr         = (in_action == ACT_WRITE);
    sound_blocked = (in_reg_address < ADDR_SOUND_END) && (in_reg_address != ADDR_POWER)
                    && !power_r;
    wr_ok         = is_wr && !sound_blocked;

    pulses            = '0;
    pulses.sq1_len    = wr_ok && (in_reg_address == ADDR_SQ1_LEN);
    pulses.sq1_trig   = wr_ok && (in_reg_address == ADDR_SQ1_TRIG) && in_write_value[7];
    pulses.sq2_len    = wr_ok && (in_reg_address == ADDR_SQ2_LEN);
    pulses.sq2_trig   = wr_ok && (in_reg_address == ADDR_SQ2_TRIG) && in_write_value[7];
    pulses.wave_len   = wr_ok && (in_reg_address == ADDR_WAVE_LEN);
    pulses.noise_len  = wr_ok && (in_reg_address == ADDR_NOISE_LEN);
    pulses.noise_trig = wr_ok && (in_reg_address == ADDR_NOISE_TRIG) && in_write_value[7];
    pulses.rom_unmap  = wr_ok && (in_reg_address == ADDR_BOOT) && (in_write_value == 8'd1);
    pulses.dma_req    = wr_ok && (in_reg_address == ADDR_DMA);

    // Store write; DMA, boot unmap and the last address are never stored
    mem_we = in_accept && wr_ok && (in_reg_address != ADDR_DMA)
             && (in_reg_address != ADDR_BOOT) && (in_reg_address != ADDR_LAST);
    case (in_reg_address)
      ADDR_POWER:    wdata = in_write_value & POWER_BIT;
      ADDR_LCD_STAT: wdata = in_write_value & STAT_WMASK;  // low bits never set
      default:       wdata = in_write_value;
    endcase

    power_off = in_accept && is_wr && (in_reg_address == ADDR_POWER) && !in_write_value[7];

    meta_in          = '0;
    meta_in.is_read  = is_rd;
    meta_in.all_ones = read_all_ones(in_reg_address);
    meta_in.mask     = read_or_mask(in_reg_address);
    meta_in.status   = !is_rd && !is_wr;
    meta_in.pulses   = pulses;
    meta_in.dma_page = pulses.dma_req ? in_write_value : 8'h00;
  end

  // Register store: at most one write and one registered read per item
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[in_reg_address] <= wdata;
    end
    if (in_accept) begin
      mem_q_r <= mem[in_reg_address];
    end
  end

  // Next valid bits: power-off wipe first, then the entry being written
  always_comb begin
    valid_nxt = valid_r;
    if (power_off) begin
      valid_nxt = valid_nxt & ~SOUND_CLR_MASK;
    end
    if (mem_we) begin
      valid_nxt[in_reg_address] = 1'b1;
    end
  end

  // Per-entry valid bits; an entry that is not valid reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      power_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (in_accept && is_wr && (in_reg_address == ADDR_POWER)) begin
        power_r <= in_write_value[7];
      end
    end
  end

  // Read stage control and payload
  always_comb begin
    a_valid_nxt = a_valid_r;
    if (in_accept) begin
      a_valid_nxt = 1'b1;
    end else if (a_adv) begin
      a_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      a_meta_r <= meta_in;
      ent_q_r  <= valid_r[in_reg_address];
    end
  end

  // Masked read data
  always_comb begin
    if (!a_meta_r.is_read) begin
      rd_value = 8'h00;
    end else if (a_meta_r.all_ones) begin
      rd_value = 8'hFF;
    end else begin
      rd_value = a_meta_r.mask | (ent_q_r ? mem_q_r : 8'h00);
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (a_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      out_read_r <= rd_value;
      out_meta_r <= a_meta_r;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_read_value          = out_read_r;
  assign out_status              = out_meta_r.status;
  assign out_sq1_length_reload   = out_meta_r.pulses.sq1_len;
  assign out_sq1_trigger         = out_meta_r.pulses.sq1_trig;
  assign out_sq2_length_reload   = out_meta_r.pulses.sq2_len;
  assign out_sq2_trigger         = out_meta_r.pulses.sq2_trig;
  assign out_wave_length_reload  = out_meta_r.pulses.wave_len;
  assign out_noise_length_reload = out_meta_r.pulses.noise_len;
  assign out_noise_trigger       = out_meta_r.pulses.noise_trig;
  assign out_rom_unmap           = out_meta_r.pulses.rom_unmap;
  assign out_dma_request         = out_meta_r.pulses.dma_req;
  assign out_dma_page            = out_meta_r.dma_page;

  // Checks
  `HIORF_ASSERT_SAME(a_err_quiet, clk, rst_n, out_valid_r && out_meta_r.status,
    (out_read_r == 8'h00) && (out_meta_r.pulses == '0) && (out_meta_r.dma_page == 8'h00))
  `HIORF_ASSERT_SAME(a_one_pulse, clk, rst_n, out_valid_r,
    $countones(out_meta_r.pulses) <= 1)
  `HIORF_ASSERT_NEXT(a_power_off_wipe, clk, rst_n, power_off,
    !power_r && !valid_r[0] && !valid_r[31])
  `HIORF_ASSERT_NEXT(a_muted_no_pulse, clk, rst_n, in_accept && sound_blocked,
    a_meta_r.pulses == '0)

endmodule

`default_nettype wire

[tb/handheld_io_register_file_core_tb.sv]
// ----------------------------------------------------------------------------
// handheld_io_register_file_core_tb
// Drives bus accesses into the I/O register window over valid/ready, with
// random gaps on the sender and random stalls on the result side. A
// scoreboard keeps its own copy of the 128-byte window, predicts every
// result and compares each field of each result with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module handheld_io_register_file_core_tb;
  import hiorf_pkg::*;

  // Command codes outside read and write
  localparam logic [1:0] ACT_BAD_LO = 2'd2;
  localparam logic [1:0] ACT_BAD_HI = 2'd3;

  // Sound registers with read masks that the package gives no name
  localparam addr_t ADDR_SQ1_DUTY   = 7'h01;
  localparam addr_t ADDR_WAVE_LEVEL = 7'h0C;
  localparam addr_t ADDR_WAVE_TRIG  = 7'h0E;

  // Unused sound addresses that read as all ones, one bit per offset
  localparam logic [31:0] UNUSED_SOUND = 32'hFF81_A928;
  localparam logic [7:0]  STAT_KEEP    = 8'h07;
  localparam int          RANDOM_ITEMS = 1150;

  typedef struct packed {
    logic [7:0] read_value;
    logic       status;
    pulse_t     pulses;
    logic [7:0] dma_page;
  } io_result_t;

  // Register window model and queue of predicted results
  class io_window_scoreboard;
    logic [7:0] regs [WINDOW_BYTES];
    io_result_t expected_results[$];
    int         errors;
    string      pulse_names[9];

    function new();
      foreach (regs[i]) regs[i] = 8'h00;
      errors = 0;
      pulse_names = '{"sq1_length_reload", "sq1_trigger", "sq2_length_reload",
                      "sq2_trigger", "wave_length_reload", "noise_length_reload",
                      "noise_trigger", "rom_unmap", "dma_request"};
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Masked read data as seen on the bus
    function logic [7:0] read_back(addr_t a);
      logic [7:0] m;
      if (a < ADDR_SOUND_END && UNUSED_SOUND[a[4:0]]) return 8'hFF;
      case (a)
        ADDR_SQ1_LEN:                    m = 8'h80;
        ADDR_SQ1_DUTY, ADDR_SQ2_LEN:     m = 8'h3F;
        ADDR_SQ1_TRIG, ADDR_SQ2_TRIG,
        ADDR_WAVE_TRIG, ADDR_NOISE_TRIG: m = 8'hBF;
        ADDR_WAVE_ON:                    m = 8'h7F;
        ADDR_WAVE_LEVEL:                 m = 8'h9F;
        ADDR_POWER:                      m = 8'h70;
        default:                         m = 8'h00;
      endcase
      return m | regs[a];
    endfunction

    // Apply one accepted access and queue the result it gives
    function void note_access(logic [1:0] act, addr_t a, logic [7:0] v);
      io_result_t r;
      logic [7:0] keep;
      r = '0;
      if (act == ACT_READ) begin
        r.read_value = read_back(a);
      end else if (act != ACT_WRITE) begin
        r.status = 1'b1;
      end else begin
        // power off wipes the sound block but keeps the wave enable
        if (a == ADDR_POWER && !v[7]) begin
          keep = regs[ADDR_WAVE_ON];
          for (int i = 0; i < 32; i++) regs[i] = 8'h00;
          regs[ADDR_WAVE_ON] = keep;
        end
        if (!(a < ADDR_SOUND_END && a != ADDR_POWER && !regs[ADDR_POWER][7])) begin
          case (a)
            ADDR_SQ1_LEN:    begin regs[a] = v; r.pulses.sq1_len = 1'b1; end
            ADDR_SQ1_TRIG:   begin regs[a] = v; r.pulses.sq1_trig = v[7]; end
            ADDR_SQ2_LEN:    begin regs[a] = v; r.pulses.sq2_len = 1'b1; end
            ADDR_SQ2_TRIG:   begin regs[a] = v; r.pulses.sq2_trig = v[7]; end
            ADDR_WAVE_LEN:   begin regs[a] = v; r.pulses.wave_len = 1'b1; end
            ADDR_NOISE_LEN:  begin regs[a] = v; r.pulses.noise_len = 1'b1; end
            ADDR_NOISE_TRIG: begin regs[a] = v; r.pulses.noise_trig = v[7]; end
            ADDR_POWER:      regs[a] = v & POWER_BIT;
            ADDR_LCD_STAT:   regs[a] = (v & STAT_WMASK) | (regs[a] & STAT_KEEP);
            ADDR_DMA: begin
              r.pulses.dma_req = 1'b1;
              r.dma_page = v;
            end
            ADDR_BOOT:       r.pulses.rom_unmap = (v == 8'd1);
            ADDR_LAST:       ;
            default:         regs[a] = v;
          endcase
        end
      end
      expected_results.push_back(r);
    endfunction

    function void report(string name, logic [7:0] exp_v, logic [7:0] got_v);
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
      errors++;
    endfunction

    // Compare one result with the oldest prediction
    function void check_result(io_result_t got);
      io_result_t exp_r;
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected, actual %0h", $time, got);
        errors++;
        return;
      end
      exp_r = expected_results.pop_front();
      if (got.read_value !== exp_r.read_value)
        report("read_value", exp_r.read_value, got.read_value);
      if (got.status !== exp_r.status)
        report("status", 8'(exp_r.status), 8'(got.status));
      for (int i = 0; i < 9; i++)
        if (got.pulses[8-i] !== exp_r.pulses[8-i])
          report(pulse_names[i], 8'(exp_r.pulses[8-i]), 8'(got.pulses[8-i]));
      if (got.dma_page !== exp_r.dma_page)
        report("dma_page", exp_r.dma_page, got.dma_page);
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_action = ACT_READ;
  addr_t      in_reg_address = '0;
  logic [7:0] in_write_value = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_read_value;
  logic       out_status;
  logic       out_sq1_length_reload;
  logic       out_sq1_trigger;
  logic       out_sq2_length_reload;
  logic       out_sq2_trigger;
  logic       out_wave_length_reload;
  logic       out_noise_length_reload;
  logic       out_noise_trigger;
  logic       out_rom_unmap;
  logic       out_dma_request;
  logic [7:0] out_dma_page;
  io_result_t seen;

  io_window_scoreboard sb = new();
  bit quiet = 1'b0;       // no gaps or stalls while set

  handheld_io_register_file_core dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_action               (in_action),
    .in_reg_address          (in_reg_address),
    .in_write_value          (in_write_value),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_read_value          (out_read_value),
    .out_status              (out_status),
    .out_sq1_length_reload   (out_sq1_length_reload),
    .out_sq1_trigger         (out_sq1_trigger),
    .out_sq2_length_reload   (out_sq2_length_reload),
    .out_sq2_trigger         (out_sq2_trigger),
    .out_wave_length_reload  (out_wave_length_reload),
    .out_noise_length_reload (out_noise_length_reload),
    .out_noise_trigger       (out_noise_trigger),
    .out_rom_unmap           (out_rom_unmap),
    .out_dma_request         (out_dma_request),
    .out_dma_page            (out_dma_page)
  );

  assign seen = {out_read_value, out_status, out_sq1_length_reload, out_sq1_trigger,
                 out_sq2_length_reload, out_sq2_trigger, out_wave_length_reload,
                 out_noise_length_reload, out_noise_trigger, out_rom_unmap,
                 out_dma_request, out_dma_page};

  initial begin
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, a few long ones
  function automatic int unsigned gap_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // Handshake monitor: inputs noted before results are checked
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note_access(in_action, in_reg_address, in_write_value);
    if (rst_n && out_valid && out_ready)
      sb.check_result(seen);
  end

  // Result side stalls
  initial begin : sink_stall
    int unsigned n;
    forever begin
      n = gap_cycles();
      if (n != 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // One bus access; valid stays high into the next call when no gap follows
  task automatic send_access(input logic [1:0] act, input addr_t a, input logic [7:0] v);
    int unsigned n;
    in_valid       <= 1'b1;
    in_action      <= act;
    in_reg_address <= a;
    in_write_value <= v;
    do @(posedge clk); while (!in_ready);
    n = gap_cycles();
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Hold the sender until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned counted;
    int unsigned r;
    logic [1:0]  act;
    addr_t       a;
    logic [7:0]  v;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset values, power rules, every pulse and special register
    send_access(ACT_READ, ADDR_SQ1_LEN, 8'h00);
    send_access(ACT_READ, ADDR_POWER, 8'h00);
    send_access(ACT_WRITE, ADDR_SQ1_LEN, 8'h55);     // ignored, power off
    send_access(ACT_WRITE, ADDR_POWER, 8'hFF);
    send_access(ACT_WRITE, ADDR_SQ1_LEN, 8'hFF);
    send_access(ACT_WRITE, ADDR_SQ1_TRIG, 8'h80);
    send_access(ACT_WRITE, ADDR_SQ1_TRIG, 8'h7F);
    send_access(ACT_WRITE, ADDR_SQ2_LEN, 8'h00);
    send_access(ACT_WRITE, ADDR_SQ2_TRIG, 8'hFF);
    send_access(ACT_WRITE, ADDR_WAVE_ON, 8'hFF);
    send_access(ACT_WRITE, ADDR_WAVE_LEN, 8'h01);
    send_access(ACT_WRITE, ADDR_NOISE_LEN, 8'h3F);
    send_access(ACT_WRITE, ADDR_NOISE_TRIG, 8'h80);
    send_access(ACT_WRITE, ADDR_LCD_STAT, 8'hFF);
    send_access(ACT_WRITE, ADDR_LCD_STAT, 8'h00);
    send_access(ACT_READ, ADDR_LCD_STAT, 8'h00);
    send_access(ACT_WRITE, ADDR_DMA, 8'hA5);
    send_access(ACT_READ, ADDR_DMA, 8'h00);
    send_access(ACT_WRITE, ADDR_BOOT, 8'h01);
    send_access(ACT_WRITE, ADDR_BOOT, 8'h81);
    send_access(ACT_WRITE, ADDR_LAST, 8'hFF);
    send_access(ACT_READ, ADDR_LAST, 8'h00);
    send_access(ACT_BAD_LO, ADDR_SOUND_END, 8'hFF);
    send_access(ACT_BAD_HI, ADDR_LAST, 8'h00);
    send_access(ACT_READ, ADDR_WAVE_LEN, 8'h00);
    send_access(ACT_WRITE, ADDR_POWER, 8'h7F);       // power off wipes sound
    send_access(ACT_READ, ADDR_WAVE_ON, 8'h00);
    send_access(ACT_READ, ADDR_SQ1_LEN, 8'h00);
    drain();

    // random: mostly powered-on sound traffic, some power cycling and noise
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if (counted % 64 == 0) quiet = ($urandom_range(0, 4) == 0);
      if (counted == RANDOM_ITEMS / 2) drain();

      r = $urandom_range(0, 99);
      if (r < 45)      act = ACT_READ;
      else if (r < 92) act = ACT_WRITE;
      else             act = ($urandom_range(0, 1) != 0) ? ACT_BAD_HI : ACT_BAD_LO;

      r = $urandom_range(0, 99);
      if (r < 50)      a = addr_t'($urandom_range(0, 31));
      else if (r < 58) a = ADDR_POWER;
      else if (r < 70) begin
        case ($urandom_range(0, 3))
          0:       a = ADDR_LCD_STAT;
          1:       a = ADDR_DMA;
          2:       a = ADDR_BOOT;
          default: a = ADDR_LAST;
        endcase
      end else a = addr_t'($urandom_range(0, 127));

      v = 8'($urandom_range(0, 255));
      if (a == ADDR_BOOT && $urandom_range(0, 2) == 0) v = 8'd1;
      if (a == ADDR_POWER) v[7] = ($urandom_range(0, 9) < 8);

      counted++;
      send_access(act, a, v);
    end

    drain();
    repeat (6) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // Run limit
  initial begin
    #3000000;
    $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
+incdir+hdl
hdl/hiorf_pkg.sv
hdl/handheld_io_register_file_core.sv
tb/handheld_io_register_file_core_tb.sv
